### hw/rtl/hvpl_pkg.sv
// ----------------------------------------------------------------------------
// hvpl_pkg: shared types, constants and tables for the haversine path length
// Arctangent table, CORDIC gain and fixed-point constants.
// ----------------------------------------------------------------------------
package hvpl_pkg;

    localparam int CordicIterDefault = 24;
    localparam int LengthBitsDefault = 40;
    localparam int OutLenBits        = 40;
    localparam int RadiusBits        = 23;
    localparam logic [RadiusBits-1:0] RadiusReset = 23'd6371000;

    localparam logic signed [63:0] CordicGain = 64'sd652032875;
    localparam logic signed [63:0] OneQ30     = 64'sd1073741824;
    localparam logic [31:0]        Pi1000Q16  = 32'd205887416;

    // degrees*1e7 to binary angle: round(v * 2^22 / BamDivisor), done as a
    // radix-2^11 long division with a reciprocal estimate per digit
    localparam logic [21:0] BamDivisor = 22'd3515625;
    localparam logic [13:0] BamRecip   = 14'd9773;    // floor(2^35 / BamDivisor)
    localparam logic [10:0] BamRoundHi = 11'd858;     // rounding half, upper digit
    localparam logic [10:0] BamRoundLo = 11'd628;     // rounding half, lower digit

    // pair of points handed from the front end to the distance engine
    typedef struct packed {
        logic signed [30:0] lat_a;
        logic signed [31:0] lon_a;
        logic signed [30:0] lat_b;
        logic signed [31:0] lon_b;
        logic               have_prev;
        logic               last;
    } job_t;

    function automatic logic signed [63:0] atan_at(input logic [5:0] i);
        logic signed [63:0] r;
        begin
            case (i)
                6'd0:  r = 64'sd536870912;
                6'd1:  r = 64'sd316933406;
                6'd2:  r = 64'sd167458907;
                6'd3:  r = 64'sd85004756;
                6'd4:  r = 64'sd42667331;
                6'd5:  r = 64'sd21354465;
                6'd6:  r = 64'sd10679838;
                6'd7:  r = 64'sd5340245;
                6'd8:  r = 64'sd2670163;
                6'd9:  r = 64'sd1335087;
                6'd10: r = 64'sd667544;
                6'd11: r = 64'sd333772;
                6'd12: r = 64'sd166886;
                6'd13: r = 64'sd83443;
                6'd14: r = 64'sd41722;
                6'd15: r = 64'sd20861;
                6'd16: r = 64'sd10430;
                6'd17: r = 64'sd5215;
                6'd18: r = 64'sd2608;
                6'd19: r = 64'sd1304;
                6'd20: r = 64'sd652;
                6'd21: r = 64'sd326;
                6'd22: r = 64'sd163;
                6'd23: r = 64'sd81;
                6'd24: r = 64'sd41;
                6'd25: r = 64'sd20;
                6'd26: r = 64'sd10;
                6'd27: r = 64'sd5;
                6'd28: r = 64'sd3;
                6'd29: r = 64'sd1;
                6'd30: r = 64'sd1;
                default: r = 64'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/hvpl_front.sv
// ----------------------------------------------------------------------------
// hvpl_front: point intake
// Accepts points, pairs each with the previous point of the path and pushes
// a job into a two-entry queue toward the distance engine.
// ----------------------------------------------------------------------------
module hvpl_front
    import hvpl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [62:0] s_tdata,
    input  logic        s_tlast,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    job_t               q_reg [2];
    logic               rd_reg, wr_reg;
    logic [1:0]         cnt_reg;
    logic signed [30:0] plat_reg;
    logic signed [31:0] plon_reg;
    logic               have_reg;
    job_t               in_job;
    logic               push, pop;

    assign s_tready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        in_job.lat_a     = plat_reg;
        in_job.lon_a     = plon_reg;
        in_job.lat_b     = s_tdata[30:0];
        in_job.lon_b     = s_tdata[62:31];
        in_job.have_prev = have_reg;
        in_job.last      = s_tlast;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            plat_reg <= '0;
            plon_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
                if (s_tlast)
                begin
                    plat_reg <= '0;
                    plon_reg <= '0;
                    have_reg <= 1'b0;
                end
                else
                begin
                    plat_reg <= s_tdata[30:0];
                    plon_reg <= s_tdata[62:31];
                    have_reg <= 1'b1;
                end
            end
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### hw/rtl/hvpl_engine.sv
// ----------------------------------------------------------------------------
// hvpl_engine: distance sequencer
// One shared CORDIC stage, a 32x32 multiplier shared by the product steps and a
// bit-serial root run the haversine steps in turn; the running total is kept here.
// ----------------------------------------------------------------------------
module hvpl_engine
    import hvpl_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDefault,
    parameter int LENGTH_BITS       = LengthBitsDefault
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  job_t                  job,
    input  logic [RadiusBits-1:0] radius,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OutLenBits-1:0] m_length,
    output logic                  m_path_end,
    output logic                  m_saturated
);

    localparam int IterBits = $clog2(CORDIC_ITERATIONS + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_BAM   = 5'd1;
    localparam logic [4:0] ST_SCSET = 5'd2;
    localparam logic [4:0] ST_ROT   = 5'd3;
    localparam logic [4:0] ST_SCEND = 5'd4;
    localparam logic [4:0] ST_M1    = 5'd5;
    localparam logic [4:0] ST_M2    = 5'd6;
    localparam logic [4:0] ST_M3    = 5'd7;
    localparam logic [4:0] ST_M4    = 5'd8;
    localparam logic [4:0] ST_H     = 5'd9;
    localparam logic [4:0] ST_SQ    = 5'd10;
    localparam logic [4:0] ST_VSET  = 5'd11;
    localparam logic [4:0] ST_VEC   = 5'd12;
    localparam logic [4:0] ST_D1    = 5'd13;
    localparam logic [4:0] ST_D2    = 5'd14;
    localparam logic [4:0] ST_D3    = 5'd15;
    localparam logic [4:0] ST_D4    = 5'd16;
    localparam logic [4:0] ST_ACC   = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;
    localparam logic [4:0] ST_CVSET = 5'd19;
    localparam logic [4:0] ST_CVEST = 5'd20;
    localparam logic [4:0] ST_CVREM = 5'd21;
    localparam logic [4:0] ST_CVFIX = 5'd22;

    localparam logic [LENGTH_BITS-1:0] MaxLen = {LENGTH_BITS{1'b1}};

    logic [4:0]               st_reg;
    logic [IterBits-1:0]      it_reg;
    logic [1:0]               sel_reg;
    logic [4:0]               sq_reg;
    logic                     sqsel_reg;
    logic                     neg_reg;
    logic signed [63:0]       x_reg, y_reg, z_reg;
    logic [31:0]              bam_reg [4];
    logic signed [63:0]       sn_reg [4];
    logic signed [63:0]       cs_reg [4];
    logic signed [63:0]       p_reg, q_reg, h_reg;
    logic [63:0]              n_reg, res_reg, bit_reg;
    logic [63:0]              ra_reg, rb_reg;
    logic signed [63:0]       prod_reg;
    logic [63:0]              t_reg, acc_reg;
    logic [LENGTH_BITS-1:0]   total_reg;
    logic                     sat_reg;
    logic                     have_reg, last_reg;
    logic [OutLenBits-1:0]    len_reg;
    logic                     oend_reg, osat_reg, oval_reg;
    logic [32:0]              cv_x_reg, cv_q_reg;
    logic [11:0]              cv_est_reg;
    logic [22:0]              cv_rem_reg;
    logic [1:0]               cv_dig_reg;
    logic                     cv_neg_reg;
    logic signed [31:0]       ma, mb;
    logic signed [63:0]       mul;

    // signed 32x32 product to 64 bits: the operands here stay below 2^31 in magnitude
    assign mul = ma * mb;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (st_reg)
            ST_M1:   begin ma = cs_reg[2][31:0]; mb = cs_reg[3][31:0]; end
            ST_M2:   begin ma = p_reg[31:0];      mb = sn_reg[1][31:0]; end
            ST_M3:   begin ma = sn_reg[0][31:0];  mb = sn_reg[0][31:0]; end
            ST_M4:   begin ma = q_reg[31:0];      mb = sn_reg[1][31:0]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign job_ready   = (st_reg == ST_IDLE);
    assign m_tvalid    = oval_reg;
    assign m_length    = len_reg;
    assign m_path_end  = oend_reg;
    assign m_saturated = osat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            it_reg    <= '0;
            sel_reg   <= '0;
            sq_reg    <= '0;
            sqsel_reg <= 1'b0;
            total_reg <= '0;
            sat_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (oval_reg && m_tready)
                oval_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        have_reg <= job.have_prev;
                        last_reg <= job.last;
                        // raw coordinates, converted in place below
                        bam_reg[2] <= 32'(job.lat_a);
                        bam_reg[3] <= 32'(job.lat_b);
                        bam_reg[0] <= job.lon_a;
                        bam_reg[1] <= job.lon_b;
                        sel_reg <= 2'd0;
                        st_reg <= job.have_prev ? ST_CVSET : ST_ACC;
                        acc_reg <= '0;
                    end
                end
                ST_CVSET:
                begin
                    cv_neg_reg <= bam_reg[sel_reg][31];
                    cv_x_reg <= {1'b0, bam_reg[sel_reg][31]
                        ? (32'd0 - bam_reg[sel_reg]) : bam_reg[sel_reg]};
                    cv_q_reg <= '0;
                    cv_dig_reg <= '0;
                    st_reg <= ST_CVEST;
                end
                ST_CVEST:
                begin
                    // digit estimate from the top bits, low by at most one
                    cv_est_reg <= 12'((36'(cv_x_reg[32:11]) * 36'(BamRecip)) >> 24);
                    st_reg <= ST_CVREM;
                end
                ST_CVREM:
                begin
                    cv_rem_reg <= 23'(cv_x_reg - 33'(cv_est_reg) * 33'(BamDivisor));
                    st_reg <= ST_CVFIX;
                end
                ST_CVFIX:
                begin
                    logic [11:0] dig;
                    logic [22:0] rm;
                    logic [32:0] qn;
                    logic [31:0] mag;
                    dig = cv_est_reg;
                    rm = cv_rem_reg;
                    if (rm >= 23'(BamDivisor))
                    begin
                        dig = dig + 12'd1;
                        rm = rm - 23'(BamDivisor);
                    end
                    qn = (cv_q_reg << 11) + 33'(dig);
                    mag = qn[31:0];
                    cv_q_reg <= qn;
                    if (cv_dig_reg == 2'd2)
                    begin
                        bam_reg[sel_reg] <= cv_neg_reg ? (32'd0 - mag) : mag;
                        sel_reg <= sel_reg + 2'd1;
                        st_reg <= (sel_reg == 2'd3) ? ST_BAM : ST_CVSET;
                    end
                    else
                    begin
                        // bring down the next digit of the rounding half
                        cv_x_reg <= {rm[21:0],
                            (cv_dig_reg == 2'd0) ? BamRoundHi : BamRoundLo};
                        cv_dig_reg <= cv_dig_reg + 2'd1;
                        st_reg <= ST_CVEST;
                    end
                end
                ST_BAM:
                begin
                    bam_reg[0] <= (bam_reg[3] - bam_reg[2]) >> 1;
                    bam_reg[1] <= (bam_reg[1] - bam_reg[0]) >> 1;
                    sel_reg <= 2'd0;
                    st_reg <= ST_SCSET;
                end
                ST_SCSET:
                begin
                    logic signed [63:0] s;
                    s = $signed({32'd0, bam_reg[sel_reg]})
                        - (bam_reg[sel_reg][31] ? 64'sh1_0000_0000 : 64'sd0);
                    neg_reg <= 1'b0;
                    if (s > OneQ30)
                    begin
                        s = 64'sh8000_0000 - s;
                        neg_reg <= 1'b1;
                    end
                    else if (s < -OneQ30)
                    begin
                        s = -64'sh8000_0000 - s;
                        neg_reg <= 1'b1;
                    end
                    x_reg <= CordicGain;
                    y_reg <= '0;
                    z_reg <= s;
                    it_reg <= '0;
                    st_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - (y_reg >>> it_reg);
                        y_reg <= y_reg + (x_reg >>> it_reg);
                        z_reg <= z_reg - atan_at(6'(it_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + (y_reg >>> it_reg);
                        y_reg <= y_reg - (x_reg >>> it_reg);
                        z_reg <= z_reg + atan_at(6'(it_reg));
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IterBits'(CORDIC_ITERATIONS - 1))
                        st_reg <= ST_SCEND;
                end
                ST_SCEND:
                begin
                    sn_reg[sel_reg] <= y_reg;
                    cs_reg[sel_reg] <= neg_reg ? -x_reg : x_reg;
                    sel_reg <= sel_reg + 2'd1;
                    st_reg <= (sel_reg == 2'd3) ? ST_M1 : ST_SCSET;
                end
                ST_M1:
                begin
                    p_reg <= mul >>> 30;
                    st_reg <= ST_M2;
                end
                ST_M2:
                begin
                    q_reg <= mul >>> 30;
                    st_reg <= ST_M3;
                end
                ST_M3:
                begin
                    prod_reg <= mul;
                    st_reg <= ST_M4;
                end
                ST_M4:
                begin
                    h_reg <= prod_reg + mul;
                    st_reg <= ST_H;
                end
                ST_H:
                begin
                    logic signed [63:0] hc;
                    hc = h_reg;
                    if (hc < 0)
                        hc = 0;
                    if (hc > 64'sh1000_0000_0000_0000)
                        hc = 64'sh1000_0000_0000_0000;
                    h_reg <= hc;
                    n_reg <= hc;
                    res_reg <= '0;
                    bit_reg <= 64'h1000_0000_0000_0000;
                    sq_reg <= '0;
                    sqsel_reg <= 1'b0;
                    st_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (n_reg >= res_reg + bit_reg)
                    begin
                        n_reg <= n_reg - (res_reg + bit_reg);
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    sq_reg <= sq_reg + 5'd1;
                    if (sq_reg == 5'd30)
                    begin
                        if (!sqsel_reg)
                        begin
                            ra_reg <= (n_reg >= res_reg + bit_reg)
                                ? (res_reg >> 1) + bit_reg : res_reg >> 1;
                            n_reg <= 64'h1000_0000_0000_0000 - h_reg;
                            res_reg <= '0;
                            bit_reg <= 64'h1000_0000_0000_0000;
                            sq_reg <= '0;
                            sqsel_reg <= 1'b1;
                        end
                        else
                        begin
                            rb_reg <= (n_reg >= res_reg + bit_reg)
                                ? (res_reg >> 1) + bit_reg : res_reg >> 1;
                            st_reg <= ST_VSET;
                        end
                    end
                end
                ST_VSET:
                begin
                    x_reg <= rb_reg;
                    y_reg <= ra_reg;
                    z_reg <= '0;
                    it_reg <= '0;
                    st_reg <= ST_VEC;
                end
                ST_VEC:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + (y_reg >>> it_reg);
                        y_reg <= y_reg - (x_reg >>> it_reg);
                        z_reg <= z_reg + atan_at(6'(it_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg - (y_reg >>> it_reg);
                        y_reg <= y_reg + (x_reg >>> it_reg);
                        z_reg <= z_reg - atan_at(6'(it_reg));
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IterBits'(CORDIC_ITERATIONS - 1))
                        st_reg <= ST_D1;
                end
                ST_D1:
                begin
                    if (z_reg < 0)
                        z_reg <= '0;
                    else if (z_reg > OneQ30)
                        z_reg <= OneQ30;
                    t_reg <= {9'd0, radius} * {32'd0, Pi1000Q16};
                    st_reg <= ST_D2;
                end
                ST_D2:
                begin
                    // high part of radius*pi term times angle
                    prod_reg <= $signed({36'd0, t_reg[50:23]} * {32'd0, z_reg[31:0]});
                    st_reg <= ST_D3;
                end
                ST_D3:
                begin
                    acc_reg <= prod_reg
                        + ((64'(t_reg[22:0]) * 64'(z_reg[31:0])) >> 23)
                        + 64'h40_0000;
                    st_reg <= ST_D4;
                end
                ST_D4:
                begin
                    acc_reg <= acc_reg >> 23;
                    st_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (!oval_reg || m_tready)
                    begin
                        logic [LENGTH_BITS:0] sum;
                        logic                 s_now;
                        sum = {1'b0, total_reg} + (LENGTH_BITS+1)'(acc_reg);
                        s_now = sat_reg;
                        if (have_reg && (sum > {1'b0, MaxLen}
                            || acc_reg[63:LENGTH_BITS] != '0))
                        begin
                            sum = {1'b0, MaxLen};
                            s_now = 1'b1;
                        end
                        if (!have_reg)
                            sum = {1'b0, total_reg};
                        len_reg  <= OutLenBits'(sum);
                        osat_reg <= s_now;
                        oend_reg <= last_reg;
                        oval_reg <= 1'b1;
                        total_reg <= last_reg ? '0 : sum[LENGTH_BITS-1:0];
                        sat_reg <= last_reg ? 1'b0 : s_now;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/haversine_path_length.sv
// Steps for a point after the first: four angle conversions, four sine and
// cosine rotations, the products, two bit-serial roots, a vectoring CORDIC, the
// distance scaling and the accumulation; a first point goes to the accumulation.
// The engine takes a new point only when idle; the front queue holds two more.
// Reset (rst_n, async): clears total, flags, previous point; radius 6371000.
// ----------------------------------------------------------------------------
// haversine_path_length: great-circle path length accumulator
// Front intake and queue feed a sequenced distance engine with an APB port.
// ----------------------------------------------------------------------------
module haversine_path_length
    import hvpl_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDefault,
    parameter int LENGTH_BITS       = LengthBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // latitude[30:0], longitude[62:31], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // length_mm[39:0]
    output logic        m_tlast,
    output logic        m_tuser,   // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [RadiusBits-1:0] radius_reg;
    logic                  job_valid, job_ready;
    job_t                  job;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {9'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RadiusReset;
        else if (psel && penable && pwrite && paddr == 2'd0)
            radius_reg <= pwdata[RadiusBits-1:0];
    end

    hvpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata[62:0]),
        .s_tlast   (s_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    hvpl_engine #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .LENGTH_BITS       (LENGTH_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .radius      (radius_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_length    (m_tdata),
        .m_path_end  (m_tlast),
        .m_saturated (m_tuser)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for haversine_path_length
// Streams path points through the block. A bit-exact fixed-point model of the
// haversine length predicts each running length, and the checker compares every
// output word against it. The radius register is swept over several settings
// through the APB port, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import hvpl_pkg::*;

    localparam int       Iters    = 24;
    localparam longint   Q30One   = 64'sd1073741824;
    localparam longint   Q60One   = 64'sd1 << 60;
    localparam longint   MaxTotal = (64'sd1 << 40) - 1;
    localparam logic [1:0] RegRadius = 2'd0;
    localparam int       SettleCycles = 260;

    typedef struct {
        logic [39:0] length_mm;
        logic        path_end;
        logic        saturated;
    } length_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    longint angle_step [0:39] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    // predictor state
    logic [22:0]  radius_m;
    longint       last_lat;
    longint       last_lon;
    bit           have_last;
    longint       run_mm;
    bit           run_sat;

    length_word_t lengths_due[$];
    int           errors;
    bit           send_idle;
    bit           recv_idle;

    haversine_path_length dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point length model
    // ------------------------------------------------------------------
    function automatic logic [31:0] deg_to_angle(input longint v);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        r = ((mag << 22) + 64'd1757812) / 64'd3515625;
        return (v < 0) ? 32'(-r) : 32'(r);
    endfunction

    task automatic rotate(input logic [31:0] a, output longint sn, output longint cs);
        longint s;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        s = longint'({32'd0, a}) - (a[31] ? (64'sd1 << 32) : 64'sd0);
        flip = 1'b0;
        if (s > Q30One)
        begin
            s = (64'sd1 << 31) - s;
            flip = 1'b1;
        end
        else if (s < -Q30One)
        begin
            s = -(64'sd1 << 31) - s;
            flip = 1'b1;
        end
        x = 64'sd652032875;
        y = 0;
        z = s;
        for (int i = 0; i < Iters; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= angle_step[i];
            end
            else
            begin
                x += dx; y -= dy; z += angle_step[i];
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endtask

    function automatic longint root_q30(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 60;
        for (int i = 0; i < 31; i++)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    task automatic hop_mm(input longint lat_a, input longint lon_a, input longint lat_b,
                          input longint lon_b, output longint mm);
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] dlat;
        logic [31:0] dlon;
        longint s1, c1, s2, c2, sa, ca, sb, cb;
        longint p, q, h, ya, xb, z, dx, dy;
        longint unsigned t, th, tl;
        pa = deg_to_angle(lat_a);
        pb = deg_to_angle(lat_b);
        dlat = (pb - pa) >> 1;
        dlon = (deg_to_angle(lon_b) - deg_to_angle(lon_a)) >> 1;
        rotate(dlat, s1, c1);
        rotate(dlon, s2, c2);
        rotate(pa, sa, ca);
        rotate(pb, sb, cb);
        p = (ca * cb) >>> 30;
        q = (p * s2) >>> 30;
        h = s1 * s1 + q * s2;
        if (h < 0) h = 0;
        if (h > Q60One) h = Q60One;
        ya = root_q30(h);
        xb = root_q30(Q60One - h);
        z = 0;
        for (int i = 0; i < Iters; i++)
        begin
            dx = ya >>> i;
            dy = xb >>> i;
            if (ya >= 0)
            begin
                xb += dx; ya -= dy; z += angle_step[i];
            end
            else
            begin
                xb -= dx; ya += dy; z -= angle_step[i];
            end
        end
        if (z < 0) z = 0;
        if (z > Q30One) z = Q30One;
        t = longint'(radius_m) * 64'd205887416;
        th = t >> 23;
        tl = t & 64'h7FFFFF;
        mm = longint'((th * z + ((tl * z) >> 23) + (64'd1 << 22)) >> 23);
    endtask

    task automatic advance_path(input logic [30:0] lat_bits, input logic [31:0] lon_bits,
                                input bit fin);
        longint       lat;
        longint       lon;
        longint       mm;
        length_word_t w;
        lat = longint'($signed(lat_bits));
        lon = longint'($signed(lon_bits));
        if (have_last)
        begin
            hop_mm(last_lat, last_lon, lat, lon, mm);
            run_mm += mm;
            if (run_mm > MaxTotal)
            begin
                run_mm = MaxTotal;
                run_sat = 1'b1;
            end
        end
        w.length_mm = run_mm[39:0];
        w.path_end = fin;
        w.saturated = run_sat;
        lengths_due.push_back(w);
        if (fin)
        begin
            run_mm = 0; run_sat = 0; have_last = 0; last_lat = 0; last_lon = 0;
        end
        else
        begin
            last_lat = lat; last_lon = lon; have_last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // stream and register drivers
    // ------------------------------------------------------------------
    task automatic send_point(input logic [30:0] lat, input logic [31:0] lon, input bit fin);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, lon, lat};
        s_tlast <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        advance_path(lat, lon, fin);
        // hold valid high for back-to-back words, drop it only for a gap
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (lengths_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_radius(input logic [31:0] value);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= RegRadius; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        radius_m = value[22:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[22:0] !== value[22:0])
        begin
            $display("%0t radius readback: expected %0d actual %0d", $time,
                     value[22:0], prdata[22:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [30:0] any_lat(input bit wild);
        if (wild)
            return 31'($urandom);
        return 31'($urandom_range(0, 1800000000) - 900000000);
    endfunction

    function automatic logic [31:0] any_lon(input bit wild);
        if (wild)
            return $urandom;
        return 32'(longint'($urandom_range(0, 3600000000)) - 64'sd1800000000);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_edge_points;
        send_point(31'sd0, 32'sd0, 1'b1);                   // one-point path
        send_point(31'sd0, 32'sd0, 1'b0);
        send_point(31'sd0, 32'sd10000000, 1'b0);
        send_point(31'sd0, 32'sd10000000, 1'b0);            // zero-length hop
        send_point(31'sd900000000, 32'sd0, 1'b0);
        send_point(-31'sd900000000, 32'sd0, 1'b0);          // pole to pole
        send_point(31'sd0, 32'sd1800000000, 1'b0);
        send_point(31'sd0, -32'sd1800000000, 1'b0);
        send_point(31'sd0, 32'sd0, 1'b1);                   // antipode, end
        send_point(31'h40000000, 32'h80000000, 1'b0);       // field minima
        send_point(31'h3FFFFFFF, 32'h7FFFFFFF, 1'b0);       // field maxima
        send_point(31'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_point(31'sd123456789, -32'sd987654321, 1'b1);
        send_point(31'sd450000000, 32'sd450000000, 1'b1);   // last with no previous
        send_point(31'sd1, 32'sd1, 1'b0);
        send_point(31'sd2, 32'sd1, 1'b1);
    endtask

    task automatic test_radius_settings;
        logic [31:0] radii [6] = '{32'd6000000, 32'd7000000, 32'd0, 32'd8388607,
                                   32'hFFFFFFFF, 32'd6371000};
        foreach (radii[r])
        begin
            write_radius(radii[r]);
            send_point(31'sd515000000, -32'sd1200000, 1'b0);
            send_point(31'sd488500000, 32'sd23500000, 1'b0);
            send_point(-31'sd338000000, 32'sd1512000000, 1'b1);
        end
    endtask

    task automatic test_saturation;
        write_radius(32'd8388607);
        for (int i = 0; i < 50; i++)
            send_point(31'($urandom_range(0, 2000)), (i % 2) ? 32'sd1800000000 : 32'sd0,
                       1'b0);
        send_point(31'sd0, 32'sd900000000, 1'b1);
        send_point(31'sd0, 32'sd0, 1'b0);
        send_point(31'sd0, 32'sd1800000000, 1'b1);          // flag cleared again
        write_radius(32'd6371000);
    endtask

    task automatic test_random_paths(input int target);
        int          n;
        int          len;
        int          kind;
        logic [30:0] lat;
        logic [31:0] lon;
        n = 0;
        while (n < target)
        begin
            if (n > target / 3 && n < target / 3 + 8)
            begin
                drain();
                write_radius(6000000 + $urandom_range(0, 1000000));
            end
            if (n >= target - 120)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            len = $urandom_range(1, 10);
            kind = $urandom_range(0, 9);
            lat = any_lat(kind == 0);
            lon = any_lon(kind == 0);
            for (int k = 0; k < len; k++)
            begin
                if (kind == 1)
                begin
                    // short city-scale hops
                    lat = lat + 31'($urandom_range(0, 20000)) - 31'd10000;
                    lon = lon + 32'($urandom_range(0, 20000)) - 32'd10000;
                end
                else if (k != 0)
                begin
                    lat = any_lat(kind == 0 || $urandom_range(0, 15) == 0);
                    lon = any_lon(kind == 0 || $urandom_range(0, 15) == 0);
                end
                send_point(lat, lon, k == len - 1 || $urandom_range(0, 30) == 0);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver stalls and checker
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge clk)
    begin
        if (!recv_idle)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        length_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (lengths_due.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %0d/%0b/%0b", $time,
                         m_tdata, m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                w = lengths_due.pop_front();
                if (m_tdata !== w.length_mm)
                begin
                    $display("%0t length_mm: expected %0d actual %0d", $time,
                             w.length_mm, m_tdata);
                    errors++;
                end
                if (m_tlast !== w.path_end)
                begin
                    $display("%0t path_end: expected %0b actual %0b", $time,
                             w.path_end, m_tlast);
                    errors++;
                end
                if (m_tuser !== w.saturated)
                begin
                    $display("%0t saturated: expected %0b actual %0b", $time,
                             w.saturated, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40000000;
        $display("[haversine_path_length] ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_tready = 1'b0;
        stall_left = 0;
        errors = 0;
        radius_m = RadiusReset;
        last_lat = 0; last_lon = 0; have_last = 0; run_mm = 0; run_sat = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_points();
        test_radius_settings();
        test_saturation();
        test_random_paths(950);

        s_tvalid <= 1'b0;
        while (lengths_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (errors == 0)
            $display("[haversine_path_length] OK");
        else
            $display("[haversine_path_length] ERROR");
        $finish;
    end

endmodule
